### hdl/length_prefixed_packet_ring_macros.svh
// Assertion macros for the length-prefixed packet ring checker.
// No dependencies; expects clk and rst_n in the scope of use.
`ifndef LENGTH_PREFIXED_PACKET_RING_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_RING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LPR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/lpr_pkg.sv
// Shared types and constants of the length-prefixed packet ring.
// No dependencies; used by the controller, datapath and top level.
package lpr_pkg;

  localparam int LPR_RING_DEPTH       = 1024;
  localparam int LPR_MAX_PAYLOAD      = 64;
  localparam int LPR_HDR_BYTES        = 2;
  localparam int LPR_SIZE_MARGIN      = 8;
  localparam int LPR_RB_W             = 11;
  localparam int LPR_RING_BYTES_RESET = 1024;

  localparam logic LPR_CFG_OVERWRITE  = 1'b0;
  localparam logic LPR_CFG_RING_BYTES = 1'b1;

  localparam logic LPR_ACT_PUSH = 1'b0;
  localparam logic LPR_ACT_POP  = 1'b1;

  typedef enum logic [2:0] {
    ST_BYTE     = 3'd0,
    ST_STORED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_TOO_LONG = 3'd4
  } lpr_status_t;

  typedef struct packed {
    logic        stage_push;
    logic        stage_clear;
    logic        rd_next;
    logic        lo_capture;
    logic        drop_apply;
    logic        hdr_wr0;
    logic        hdr_wr1;
    logic        copy_wr;
    logic        commit;
    logic        pop_hdr;
    logic        pop_byte;
    logic        emit;
    lpr_status_t emit_status;
  } lpr_cmd_t;

  typedef struct packed {
    logic ovf;
    logic cnt_zero;
    logic reject;
    logic need_drop;
    logic used_zero;
    logic pop_last;
    logic copy_last;
    logic out_free;
  } lpr_sts_t;

endpackage

### hdl/length_prefixed_packet_ring.sv
// Length-prefixed packet ring: a byte ring of variable-length records, each
// stored behind a two-byte little-endian length that counts itself. A push beat
// that does not end a record leaves the controller idle. A commit that is not
// rejected drops the oldest records while room is needed, then writes the
// length and copies the payload through the single write port of the ring, one
// byte per copy step, each waiting on a staging memory read. A pop emits each
// byte behind a registered ring read. Results wait in an output register, one
// beat each. Top level; depends on lpr_pkg, lpr_ctrl and lpr_datapath.
module length_prefixed_packet_ring import lpr_pkg::*; #(
  parameter int RING_DEPTH  = LPR_RING_DEPTH,
  parameter int MAX_PAYLOAD = LPR_MAX_PAYLOAD
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [LPR_RB_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_action,
  input  logic [7:0]          in_payload_byte,
  input  logic                in_end_of_record,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [7:0]          out_byte,
  output logic                out_last_of_record,
  output logic                out_records_dropped
);

  lpr_cmd_t cmd;
  lpr_sts_t sts;

  lpr_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_end_of_record (in_end_of_record),
    .sts              (sts),
    .cmd              (cmd)
  );

  lpr_datapath #(
    .RING_DEPTH  (RING_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_payload_byte     (in_payload_byte),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_byte            (out_byte),
    .out_last_of_record  (out_last_of_record),
    .out_records_dropped (out_records_dropped)
  );

endmodule

### hdl/lpr_ctrl.sv
// Controller state machine of the length-prefixed packet ring.
// Depends on lpr_pkg; drives lpr_datapath through command and status structs.
module lpr_ctrl import lpr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_action,
  input  logic     in_end_of_record,
  input  lpr_sts_t sts,
  output lpr_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_COMMIT, S_DROP_A, S_DROP_B, S_DROP_C, S_WR_H0, S_WR_H1,
    S_COPY_RD, S_COPY_WR, S_DONE, S_POP, S_POP_A, S_POP_B, S_POP_C,
    S_POP_RD, S_POP_EM
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == LPR_ACT_PUSH) begin
            cmd.stage_push = 1'b1;
            if (in_end_of_record) state_nxt = S_COMMIT;
          end else begin
            state_nxt = S_POP;
          end
        end
      end
      S_COMMIT: begin
        priority if (sts.ovf) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_TOO_LONG;
            cmd.stage_clear = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (sts.cnt_zero) begin
          state_nxt = S_IDLE;
        end else if (sts.reject) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_FULL;
            cmd.stage_clear = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (sts.need_drop) begin
          state_nxt = S_DROP_A;
        end else begin
          state_nxt = S_WR_H0;
        end
      end
      S_DROP_A: state_nxt = S_DROP_B;
      S_DROP_B: begin
        cmd.rd_next    = 1'b1;
        cmd.lo_capture = 1'b1;
        state_nxt      = S_DROP_C;
      end
      S_DROP_C: begin
        cmd.drop_apply = 1'b1;
        state_nxt      = S_COMMIT;
      end
      S_WR_H0: begin
        cmd.hdr_wr0 = 1'b1;
        state_nxt   = S_WR_H1;
      end
      S_WR_H1: begin
        cmd.hdr_wr1 = 1'b1;
        state_nxt   = S_COPY_RD;
      end
      S_COPY_RD: state_nxt = S_COPY_WR;
      S_COPY_WR: begin
        cmd.copy_wr = 1'b1;
        state_nxt   = sts.copy_last ? S_DONE : S_COPY_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_STORED;
          cmd.commit      = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_POP: begin
        if (sts.used_zero) begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_EMPTY;
            state_nxt       = S_IDLE;
          end
        end else begin
          state_nxt = S_POP_A;
        end
      end
      S_POP_A: state_nxt = S_POP_B;
      S_POP_B: begin
        cmd.rd_next    = 1'b1;
        cmd.lo_capture = 1'b1;
        state_nxt      = S_POP_C;
      end
      S_POP_C: begin
        cmd.pop_hdr = 1'b1;
        state_nxt   = S_POP_RD;
      end
      S_POP_RD: state_nxt = S_POP_EM;
      S_POP_EM: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_BYTE;
          cmd.pop_byte    = 1'b1;
          state_nxt       = sts.pop_last ? S_IDLE : S_POP_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hdl/lpr_datapath.sv
// Datapath of the length-prefixed packet ring: ring and staging memories,
// pointers, counts, configuration and the output register. Depends on lpr_pkg.
module lpr_datapath import lpr_pkg::*; #(
  parameter int RING_DEPTH  = LPR_RING_DEPTH,
  parameter int MAX_PAYLOAD = LPR_MAX_PAYLOAD
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [LPR_RB_W-1:0] cfg_data,
  input  logic [7:0]          in_payload_byte,
  input  lpr_cmd_t            cmd,
  output lpr_sts_t            sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [7:0]          out_byte,
  output logic                out_last_of_record,
  output logic                out_records_dropped
);

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int UW  = PW + 1;
  localparam int CW  = $clog2(MAX_PAYLOAD + LPR_HDR_BYTES + 1);
  localparam int SIW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int SW  = (UW > LPR_RB_W) ? UW : LPR_RB_W;
  localparam int MIN_RS = MAX_PAYLOAD + LPR_SIZE_MARGIN;
  localparam int RS_RESET_I = (LPR_RING_BYTES_RESET > RING_DEPTH) ? RING_DEPTH :
                              ((LPR_RING_BYTES_RESET < MIN_RS) ? MIN_RS :
                               LPR_RING_BYTES_RESET);
  localparam logic [UW-1:0] RS_RESET = UW'(RS_RESET_I);
  localparam logic [SW-1:0] DEPTH_S  = SW'(RING_DEPTH);
  localparam logic [SW-1:0] MIN_S    = SW'(MIN_RS);

  function automatic logic [PW-1:0] adv1(input logic [PW-1:0] p, input logic [UW-1:0] r);
    logic [UW-1:0] q;
    q = {1'b0, p} + UW'(1);
    return (q == r) ? '0 : q[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] advn(input logic [PW-1:0] p, input logic [UW-1:0] n,
                                         input logic [UW-1:0] r);
    logic [UW:0] q;
    q = {2'b00, p} + {1'b0, n};
    if (q >= {1'b0, r}) q = q - {1'b0, r};
    return q[PW-1:0];
  endfunction

  logic [7:0]    ring_mem [RING_DEPTH];
  logic [7:0]    stage_mem [MAX_PAYLOAD];
  logic [7:0]    ring_q, stage_q, lo_r;
  logic [PW-1:0] wp_r, rp_r, rd_addr;
  logic [UW-1:0] used_r, rsize_r;
  logic [CW-1:0] cnt_r, idx_r, n_r, size, len_c;
  logic          ovf_r, ovw_r, dropped_r;
  logic [UW:0]   need_sum;
  logic [15:0]   size16, hdr;
  logic [SW-1:0] rb_s, rb_clamp;
  logic          ring_we;
  logic [7:0]    ring_wd;
  logic          out_valid_r, out_last_r, out_drop_r;
  logic [2:0]    out_status_r;
  logic [7:0]    out_byte_r;

  assign size     = cnt_r + CW'(LPR_HDR_BYTES);
  assign size16   = 16'(size);
  assign need_sum = {1'b0, used_r} + (UW + 1)'(size);
  assign hdr      = {ring_q, lo_r};
  assign len_c    = hdr[CW-1:0];
  assign rd_addr  = cmd.rd_next ? adv1(rp_r, rsize_r) : rp_r;

  assign rb_s     = SW'(cfg_data);
  assign rb_clamp = (rb_s > DEPTH_S) ? DEPTH_S : ((rb_s < MIN_S) ? MIN_S : rb_s);

  assign sts.ovf       = ovf_r;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.need_drop = (need_sum >= {1'b0, rsize_r});
  assign sts.reject    = ((UW + 1)'(size) >= {1'b0, rsize_r}) || (sts.need_drop && !ovw_r);
  assign sts.used_zero = (used_r == '0);
  assign sts.pop_last  = (n_r == CW'(1));
  assign sts.copy_last = ((idx_r + CW'(1)) == cnt_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    ring_we = cmd.hdr_wr0 || cmd.hdr_wr1 || cmd.copy_wr;
    priority if (cmd.hdr_wr0) begin
      ring_wd = size16[7:0];
    end else if (cmd.hdr_wr1) begin
      ring_wd = size16[15:8];
    end else begin
      ring_wd = stage_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[wp_r] <= ring_wd;
    ring_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.stage_push && (cnt_r < CW'(MAX_PAYLOAD))) begin
      stage_mem[cnt_r[SIW-1:0]] <= in_payload_byte;
    end
    stage_q <= stage_mem[idx_r[SIW-1:0]];
    if (cmd.lo_capture) lo_r <= ring_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      used_r    <= '0;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      ovw_r     <= 1'b0;
      rsize_r   <= RS_RESET;
      idx_r     <= '0;
      n_r       <= '0;
      dropped_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == LPR_CFG_OVERWRITE) begin
          ovw_r <= cfg_data[0];
        end else begin
          rsize_r <= UW'(rb_clamp);
          wp_r    <= '0;
          rp_r    <= '0;
          used_r  <= '0;
        end
      end
      if (cmd.stage_push) begin
        if (cnt_r < CW'(MAX_PAYLOAD)) cnt_r <= cnt_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.stage_clear) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
      if (cmd.drop_apply) begin
        rp_r      <= advn(rp_r, UW'(len_c), rsize_r);
        used_r    <= used_r - UW'(len_c);
        dropped_r <= 1'b1;
      end
      if (cmd.hdr_wr0) begin
        wp_r  <= adv1(wp_r, rsize_r);
        idx_r <= '0;
      end
      if (cmd.hdr_wr1) wp_r <= adv1(wp_r, rsize_r);
      if (cmd.copy_wr) begin
        wp_r  <= adv1(wp_r, rsize_r);
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.commit) begin
        used_r    <= used_r + UW'(size);
        cnt_r     <= '0;
        ovf_r     <= 1'b0;
        dropped_r <= 1'b0;
      end
      if (cmd.pop_hdr) begin
        n_r    <= len_c - CW'(LPR_HDR_BYTES);
        used_r <= used_r - UW'(len_c);
        rp_r   <= advn(rp_r, UW'(LPR_HDR_BYTES), rsize_r);
      end
      if (cmd.pop_byte) begin
        rp_r <= adv1(rp_r, rsize_r);
        n_r  <= n_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_byte_r   <= (cmd.emit_status == ST_BYTE) ? ring_q : 8'd0;
      out_last_r   <= (cmd.emit_status == ST_BYTE) ? sts.pop_last : 1'b1;
      out_drop_r   <= (cmd.emit_status == ST_STORED) ? dropped_r : 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_byte            = out_byte_r;
  assign out_last_of_record  = out_last_r;
  assign out_records_dropped = out_drop_r;

endmodule

### hdl/lpr_checker.sv
// Port-level checker of the length-prefixed packet ring, bound to the top level.
// Depends on lpr_pkg and length_prefixed_packet_ring_macros.svh.
`include "length_prefixed_packet_ring_macros.svh"
module lpr_checker import lpr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [7:0] out_byte,
  input logic       out_last_of_record,
  input logic       out_records_dropped
);

  `LPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled beat dropped")
  `LPR_ASSERT_IMPL(a_last_non_byte, out_valid && (out_status != ST_BYTE), out_last_of_record, "non-byte result without last")
  `LPR_ASSERT_IMPL(a_zero_byte, out_valid && (out_status != ST_BYTE), out_byte == 8'd0, "non-byte result carries data")
  `LPR_ASSERT_IMPL(a_drop_stored, out_valid && out_records_dropped, out_status == ST_STORED, "drop flag without store")

endmodule

bind length_prefixed_packet_ring lpr_checker u_chk (.*);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for length_prefixed_packet_ring: record pushes and pops
// are predicted by a byte-ring model kept in the bench. Depends on lpr_pkg.
module tb_top;
  import lpr_pkg::*;

  typedef struct packed {
    lpr_status_t status;
    logic [7:0]  data;
    logic        last;
    logic        dropped;
  } ring_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = LPR_CFG_OVERWRITE;
  logic [LPR_RB_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = LPR_ACT_PUSH;
  logic [7:0] in_payload_byte = '0;
  logic in_end_of_record = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [7:0] out_byte;
  logic out_last_of_record;
  logic out_records_dropped;

  length_prefixed_packet_ring DUT (.*);

  always #2 clk = ~clk;

  // Predictor state.
  logic [7:0] ring_mem [LPR_RING_DEPTH];
  logic [7:0] stage_mem [LPR_MAX_PAYLOAD];
  int wr_ptr, rd_ptr, fill, stage_cnt, ring_len_reg;
  bit stage_ovf, overwrite_mode;
  ring_result_t pending_results[$];

  int mismatches = 0, results_seen = 0, cycles = 0, beats_sent = 0;
  bit hold_off = 1'b0;
  bit out_idle_en = 1'b1;
  int hold_cycles = 0;

  function automatic int ring_limit();
    int r;
    r = ring_len_reg;
    if (r > LPR_RING_DEPTH) r = LPR_RING_DEPTH;
    if (r < LPR_MAX_PAYLOAD + LPR_SIZE_MARGIN) r = LPR_MAX_PAYLOAD + LPR_SIZE_MARGIN;
    return r;
  endfunction

  function automatic int step_ptr(int p, int n);
    int q;
    q = p + n;
    while (q >= ring_limit()) q -= ring_limit();
    return q;
  endfunction

  function automatic int stored_len(int p);
    return int'(ring_mem[p]) | (int'(ring_mem[step_ptr(p, 1)]) << 8);
  endfunction

  function automatic void add_result(lpr_status_t s, logic [7:0] d, logic l, logic dr);
    ring_result_t e;
    e.status = s; e.data = d; e.last = l; e.dropped = dr;
    pending_results.push_back(e);
  endfunction

  function automatic void predict_beat(logic act, logic [7:0] b, logic eor);
    int sz, len, p, n;
    bit drop;
    if (act == LPR_ACT_PUSH) begin
      if (stage_cnt < LPR_MAX_PAYLOAD) begin
        stage_mem[stage_cnt] = b;
        stage_cnt++;
      end else begin
        stage_ovf = 1'b1;
      end
      if (!eor) return;
      if (stage_ovf) begin
        stage_cnt = 0; stage_ovf = 0;
        add_result(ST_TOO_LONG, 8'h00, 1'b1, 1'b0);
        return;
      end
      if (stage_cnt == 0) return;
      sz = stage_cnt + LPR_HDR_BYTES;
      if (sz >= ring_limit() || (fill + sz >= ring_limit() && !overwrite_mode)) begin
        stage_cnt = 0; stage_ovf = 0;
        add_result(ST_FULL, 8'h00, 1'b1, 1'b0);
        return;
      end
      drop = 1'b0;
      while (fill + sz >= ring_limit()) begin
        len = stored_len(rd_ptr);
        if (len < LPR_HDR_BYTES || len > fill) begin
          wr_ptr = 0; rd_ptr = 0; fill = 0;
        end else begin
          rd_ptr = step_ptr(rd_ptr, len);
          fill -= len;
        end
        drop = 1'b1;
      end
      p = wr_ptr;
      ring_mem[p] = sz[7:0];
      p = step_ptr(p, 1);
      ring_mem[p] = sz[15:8];
      p = step_ptr(p, 1);
      for (int i = 0; i < stage_cnt; i++) begin
        ring_mem[p] = stage_mem[i];
        p = step_ptr(p, 1);
      end
      wr_ptr = p;
      fill += sz;
      stage_cnt = 0; stage_ovf = 0;
      add_result(ST_STORED, 8'h00, 1'b1, drop);
    end else begin
      if (fill == 0) begin
        add_result(ST_EMPTY, 8'h00, 1'b1, 1'b0);
        return;
      end
      len = stored_len(rd_ptr);
      if (len < LPR_HDR_BYTES + 1 || len > fill || len > LPR_MAX_PAYLOAD + LPR_HDR_BYTES) begin
        wr_ptr = 0; rd_ptr = 0; fill = 0;
        add_result(ST_EMPTY, 8'h00, 1'b1, 1'b0);
        return;
      end
      n = len - LPR_HDR_BYTES;
      p = step_ptr(rd_ptr, LPR_HDR_BYTES);
      for (int i = 0; i < n; i++) begin
        add_result(ST_BYTE, ring_mem[p], (i + 1 == n), 1'b0);
        p = step_ptr(p, 1);
      end
      rd_ptr = p;
      fill -= len;
    end
  endfunction

  // Result checker and receiver idling.
  always @(posedge clk) begin
    ring_result_t e;
    int w;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected beat status=%0d byte=%02h", out_status, out_byte);
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status || out_byte !== e.data ||
            out_last_of_record !== e.last || out_records_dropped !== e.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp st=%0d b=%02h l=%0b d=%0b got st=%0d b=%02h l=%0b d=%0b",
                     e.status, e.data, e.last, e.dropped, out_status, out_byte,
                     out_last_of_record, out_records_dropped);
        end
      end
    end
    w = $urandom_range(0, 9);
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (out_idle_en && rst_n && out_valid && !out_stall && w != 0) begin
      hold_cycles <= w - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (cycles > 1500000) begin
      $display("Timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  bit send_gaps = 1'b1;

  task automatic send_beat(logic act, logic [7:0] b, logic eor);
    int gap;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predict_beat(act, b, eor);
    in_valid <= 1'b1;
    in_action <= act;
    in_payload_byte <= b;
    in_end_of_record <= eor;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic push_record(int n);
    for (int i = 0; i < n; i++)
      send_beat(LPR_ACT_PUSH, 8'($urandom_range(0, 255)), i == n - 1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [LPR_RB_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == LPR_CFG_OVERWRITE) begin
      overwrite_mode = v[0];
    end else begin
      ring_len_reg = int'(v);
      wr_ptr = 0; rd_ptr = 0; fill = 0;
    end
  endtask

  task automatic test_directed();
    send_beat(LPR_ACT_POP, 8'hFF, 1'b1);
    send_beat(LPR_ACT_PUSH, 8'h00, 1'b0);
    send_beat(LPR_ACT_PUSH, 8'hFF, 1'b1);
    send_beat(LPR_ACT_PUSH, 8'hA5, 1'b1);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
  endtask

  task automatic test_too_long();
    push_record(LPR_MAX_PAYLOAD);
    push_record(LPR_MAX_PAYLOAD + 1);
    push_record(1);
    send_beat(LPR_ACT_POP, 8'h5A, 1'b1);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
  endtask

  task automatic test_reject_full();
    write_cfg(LPR_CFG_RING_BYTES, 11'd0);
    push_record(32);
    push_record(32);
    push_record(2);
    push_record(1);
  endtask

  task automatic test_overwrite();
    write_cfg(LPR_CFG_OVERWRITE, 11'd1);
    push_record(34);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
    send_beat(LPR_ACT_POP, 8'h00, 1'b0);
    write_cfg(LPR_CFG_RING_BYTES, 11'd2047);
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 4; i++) push_record(2);
        for (int i = 0; i < 4; i++) send_beat(LPR_ACT_POP, 8'h00, 1'b0);
      end
    join
    send_gaps = 1'b1;
    drain();
  endtask

  task automatic random_phase(int beats);
    int target, n;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      case ($urandom_range(0, 9))
        0: send_beat(LPR_ACT_POP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        1, 2, 3: send_beat(LPR_ACT_POP, 8'h00, 1'b0);
        4: send_beat(LPR_ACT_PUSH, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        default: begin
          n = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 68) : $urandom_range(1, 8);
          push_record(n);
        end
      endcase
      if ($urandom_range(0, 40) == 0) begin
        out_idle_en = ~out_idle_en;
        send_gaps = ~send_gaps;
      end
    end
    out_idle_en = 1'b1;
    send_gaps = 1'b1;
  endtask

  task automatic test_random();
    write_cfg(LPR_CFG_OVERWRITE, 11'd0);
    write_cfg(LPR_CFG_RING_BYTES, 11'd100);
    random_phase(6);
    write_cfg(LPR_CFG_OVERWRITE, 11'd1);
    random_phase(6);
    write_cfg(LPR_CFG_RING_BYTES, 11'd1024);
    random_phase(6);
  endtask

  initial begin
    for (int i = 0; i < LPR_RING_DEPTH; i++) ring_mem[i] = '0;
    wr_ptr = 0; rd_ptr = 0; fill = 0; stage_cnt = 0; stage_ovf = 0;
    overwrite_mode = 0; ring_len_reg = LPR_RING_BYTES_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_too_long();
    test_reject_full();
    test_overwrite();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d input beats and checked %0d result beats over several ring settings,",
             beats_sent, results_seen);
    $display("including reject, overwrite, oversize records and a long output hold-off.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
